@@ rtl/calclk_pkg.sv @@
package calclk_pkg;

  localparam int SEC_PER_MIN   = 60;
  localparam int MIN_PER_HOUR  = 60;
  localparam int HOUR_PER_DAY  = 24;
  localparam int LAST_MONTH    = 11;
  localparam int LEAP_CYCLE    = 400;
  localparam int CENTURY       = 100;
  localparam int RES_BITS      = 9;
  localparam int LOAD_YEAR_W   = 16;
  // ceil(2^16 / 25): exact floor((y >> 4) / 25) for any 12-bit y >> 4
  localparam int CYCLE_RECIP   = 2622;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_LOAD = 1'b1
  } req_t;

  typedef struct packed {
    req_t                     req_type;
    logic [5:0]               load_seconds;
    logic [5:0]               load_minutes;
    logic [4:0]               load_hours;
    logic [4:0]               load_mday;
    logic [3:0]               load_month;
    logic [LOAD_YEAR_W-1:0]   load_year;
    logic [8:0]               load_yday;
    logic [2:0]               load_wday;
    logic                     load_dst;
    logic [RES_BITS-1:0]      year_res;
  } item_t;

  // year mod 400: quotient by reciprocal multiply of year / 16 by 1/25
  function automatic logic [RES_BITS-1:0] mod_cycle(logic [LOAD_YEAR_W-1:0] v);
    logic [LOAD_YEAR_W-5:0] hi;
    logic [23:0]            prod;
    logic [7:0]             q;
    logic [LOAD_YEAR_W-1:0] r;
    hi   = v[LOAD_YEAR_W-1:4];
    prod = {12'd0, hi} * 24'(CYCLE_RECIP);
    q    = prod[23:16];
    r    = v - LOAD_YEAR_W'(q) * LOAD_YEAR_W'(LEAP_CYCLE);
    return r[RES_BITS-1:0];
  endfunction

  function automatic logic is_leap(logic [RES_BITS-1:0] r);
    logic cent;
    cent = (r == RES_BITS'(CENTURY)) || (r == RES_BITS'(2 * CENTURY)) ||
           (r == RES_BITS'(3 * CENTURY));
    return (r == '0) || ((r[1:0] == 2'd0) && !cent);
  endfunction

  function automatic logic [4:0] days_in(logic [3:0] m, logic leap);
    logic [4:0] len;
    case (m)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/calendar_clock_counter.sv @@
// channel  | signals                          | direction
// ---------+----------------------------------+----------
// input    | in_valid/in_ready, in_req_type,  | in
//          | in_load_* time fields            |
// result   | out_valid/out_ready, out_seconds | out
//          | .. out_dst                       |
//
// One item per cycle sustained while out_ready stays high; a result is valid once its input
// transfer has passed the input register, then the calendar state register (the result register).
// Year mod 400 for a load is computed in the input stage; ticks track it with the year.
// Reset (rst_n low, synchronous) sets 00:00:00, day 1, month 0, year 0; in_ready is low.
// A stalled result holds the state; the input register still takes one item.
module calendar_clock_counter #(
  parameter int YEAR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [5:0]  in_load_seconds,
  input  logic [5:0]  in_load_minutes,
  input  logic [4:0]  in_load_hours,
  input  logic [4:0]  in_load_mday,
  input  logic [3:0]  in_load_month,
  input  logic [15:0] in_load_year,
  input  logic [8:0]  in_load_yday,
  input  logic [2:0]  in_load_wday,
  input  logic        in_load_dst,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_seconds,
  output logic [5:0]  out_minutes,
  output logic [4:0]  out_hours,
  output logic [4:0]  out_mday,
  output logic [3:0]  out_month,
  output logic [15:0] out_year,
  output logic [8:0]  out_yday,
  output logic [2:0]  out_wday,
  output logic        out_dst
);

  logic              stage_valid;
  logic              take;
  calclk_pkg::item_t stage_item;

  calclk_in_stage #(
    .YEAR_BITS (YEAR_BITS)
  ) u_in_stage (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_load_seconds (in_load_seconds),
    .in_load_minutes (in_load_minutes),
    .in_load_hours   (in_load_hours),
    .in_load_mday    (in_load_mday),
    .in_load_month   (in_load_month),
    .in_load_year    (in_load_year),
    .in_load_yday    (in_load_yday),
    .in_load_wday    (in_load_wday),
    .in_load_dst     (in_load_dst),
    .take            (take),
    .stage_valid     (stage_valid),
    .stage_item      (stage_item)
  );

  calclk_core #(
    .YEAR_BITS (YEAR_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .take        (take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_seconds (out_seconds),
    .out_minutes (out_minutes),
    .out_hours   (out_hours),
    .out_mday    (out_mday),
    .out_month   (out_month),
    .out_year    (out_year),
    .out_yday    (out_yday),
    .out_wday    (out_wday),
    .out_dst     (out_dst)
  );

  a_take_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid)
    else $error("stage transfer did not produce a result");

  a_tick_seconds: assert property (@(posedge clk) disable iff (!rst_n)
    (take && stage_item.req_type == calclk_pkg::REQ_TICK && out_seconds < 6'd59)
    |=> (out_seconds == $past(out_seconds) + 6'd1) && $stable(out_minutes))
    else $error("tick without carry did not step seconds only");

  a_load_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (take && stage_item.req_type == calclk_pkg::REQ_LOAD)
    |=> (out_minutes == $past(stage_item.load_minutes)) &&
        (out_wday == $past(stage_item.load_wday)))
    else $error("load did not set the time fields");

endmodule

@@ rtl/calclk_in_stage.sv @@
module calclk_in_stage #(
  parameter int YEAR_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_req_type,
  input  logic [5:0]          in_load_seconds,
  input  logic [5:0]          in_load_minutes,
  input  logic [4:0]          in_load_hours,
  input  logic [4:0]          in_load_mday,
  input  logic [3:0]          in_load_month,
  input  logic [15:0]         in_load_year,
  input  logic [8:0]          in_load_yday,
  input  logic [2:0]          in_load_wday,
  input  logic                in_load_dst,
  input  logic                take,
  output logic                stage_valid,
  output calclk_pkg::item_t   stage_item
);

  logic              valid_r;
  calclk_pkg::item_t item_r;
  calclk_pkg::item_t item_nxt;
  logic [YEAR_BITS-1:0] year_masked;

  assign in_ready    = rst_n && (!valid_r || take);
  assign stage_valid = valid_r;
  assign stage_item  = item_r;

  always_comb begin
    year_masked            = YEAR_BITS'(in_load_year);
    item_nxt.req_type      = calclk_pkg::req_t'(in_req_type);
    item_nxt.load_seconds  = in_load_seconds;
    item_nxt.load_minutes  = in_load_minutes;
    item_nxt.load_hours    = in_load_hours;
    item_nxt.load_mday     = in_load_mday;
    item_nxt.load_month    = in_load_month;
    item_nxt.load_year     = in_load_year;
    item_nxt.load_yday     = in_load_yday;
    item_nxt.load_wday     = in_load_wday;
    item_nxt.load_dst      = in_load_dst;
    item_nxt.year_res      = calclk_pkg::mod_cycle(
                               calclk_pkg::LOAD_YEAR_W'(year_masked));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

@@ rtl/calclk_core.sv @@
module calclk_core #(
  parameter int YEAR_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                stage_valid,
  input  calclk_pkg::item_t   stage_item,
  output logic                take,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [5:0]          out_seconds,
  output logic [5:0]          out_minutes,
  output logic [4:0]          out_hours,
  output logic [4:0]          out_mday,
  output logic [3:0]          out_month,
  output logic [15:0]         out_year,
  output logic [8:0]          out_yday,
  output logic [2:0]          out_wday,
  output logic                out_dst
);

  localparam int RB = calclk_pkg::RES_BITS;

  logic                 out_valid_r;
  logic [5:0]           sec_r,  sec_nxt;
  logic [5:0]           min_r,  min_nxt;
  logic [4:0]           hour_r, hour_nxt;
  logic [4:0]           mday_r, mday_nxt;
  logic [3:0]           mon_r,  mon_nxt;
  logic [YEAR_BITS-1:0] year_r, year_nxt;
  logic [8:0]           yday_r, yday_nxt;
  logic [2:0]           wday_r, wday_nxt;
  logic                 dst_r,  dst_nxt;
  logic [RB-1:0]        res_r,  res_nxt;

  logic [6:0] sec_inc;
  logic [6:0] min_inc;
  logic [5:0] hour_inc;
  logic [5:0] mday_inc;
  logic [4:0] mon_inc;
  logic [4:0] mlen;

  assign take        = stage_valid && (!out_valid_r || out_ready);
  assign out_valid   = out_valid_r;
  assign out_seconds = sec_r;
  assign out_minutes = min_r;
  assign out_hours   = hour_r;
  assign out_mday    = mday_r;
  assign out_month   = mon_r;
  assign out_year    = 16'(year_r);
  assign out_yday    = yday_r;
  assign out_wday    = wday_r;
  assign out_dst     = dst_r;

  always_comb begin
    sec_inc  = {1'b0, sec_r} + 7'd1;
    min_inc  = {1'b0, min_r} + 7'd1;
    hour_inc = {1'b0, hour_r} + 6'd1;
    mday_inc = {1'b0, mday_r} + 6'd1;
    mon_inc  = {1'b0, mon_r} + 5'd1;
    mlen     = calclk_pkg::days_in(mon_r, calclk_pkg::is_leap(res_r));

    sec_nxt  = sec_r;
    min_nxt  = min_r;
    hour_nxt = hour_r;
    mday_nxt = mday_r;
    mon_nxt  = mon_r;
    year_nxt = year_r;
    yday_nxt = yday_r;
    wday_nxt = wday_r;
    dst_nxt  = dst_r;
    res_nxt  = res_r;

    if (stage_item.req_type == calclk_pkg::REQ_LOAD) begin
      sec_nxt  = stage_item.load_seconds;
      min_nxt  = stage_item.load_minutes;
      hour_nxt = stage_item.load_hours;
      mday_nxt = stage_item.load_mday;
      mon_nxt  = stage_item.load_month;
      year_nxt = YEAR_BITS'(stage_item.load_year);
      yday_nxt = stage_item.load_yday;
      wday_nxt = stage_item.load_wday;
      dst_nxt  = stage_item.load_dst;
      res_nxt  = stage_item.year_res;
    end else if (sec_inc < 7'(calclk_pkg::SEC_PER_MIN)) begin
      sec_nxt = sec_inc[5:0];
    end else begin
      sec_nxt = '0;
      if (min_inc < 7'(calclk_pkg::MIN_PER_HOUR)) begin
        min_nxt = min_inc[5:0];
      end else begin
        min_nxt = '0;
        if (hour_inc < 6'(calclk_pkg::HOUR_PER_DAY)) begin
          hour_nxt = hour_inc[4:0];
        end else begin
          hour_nxt = '0;
          yday_nxt = yday_r + 9'd1;
          if (mday_inc <= {1'b0, mlen}) begin
            mday_nxt = mday_inc[4:0];
          end else begin
            mday_nxt = 5'd1;
            if (mon_inc <= 5'(calclk_pkg::LAST_MONTH)) begin
              mon_nxt = mon_inc[3:0];
            end else begin
              mon_nxt  = '0;
              yday_nxt = '0;
              year_nxt = year_r + YEAR_BITS'(1);
              // residue follows the year, including the wrap to zero
              if ((&year_r) || (res_r == RB'(calclk_pkg::LEAP_CYCLE - 1))) begin
                res_nxt = '0;
              end else begin
                res_nxt = res_r + RB'(1);
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_r       <= '0;
      min_r       <= '0;
      hour_r      <= '0;
      mday_r      <= 5'd1;
      mon_r       <= '0;
      year_r      <= '0;
      yday_r      <= '0;
      wday_r      <= '0;
      dst_r       <= 1'b0;
      res_r       <= '0;
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
        sec_r       <= sec_nxt;
        min_r       <= min_nxt;
        hour_r      <= hour_nxt;
        mday_r      <= mday_nxt;
        mon_r       <= mon_nxt;
        year_r      <= year_nxt;
        yday_r      <= yday_nxt;
        wday_r      <= wday_nxt;
        dst_r       <= dst_nxt;
        res_r       <= res_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_ITEMS   = 600;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AFTER     = 60;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int FEBRUARY       = 1;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
    logic [4:0]  mday;
    logic [3:0]  month;
    logic [15:0] year;
    logic [8:0]  yday;
    logic [2:0]  wday;
    logic        dst;
  } cal_t;

  typedef struct packed {
    calclk_pkg::req_t kind;
    cal_t             load;
  } stim_t;

  localparam cal_t RESET_TIME = '{6'd0, 6'd0, 5'd0, 5'd1, 4'd0, 16'd0, 9'd0, 3'd0, 1'b0};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req_type = 1'b0;
  logic [5:0]  in_load_seconds = '0;
  logic [5:0]  in_load_minutes = '0;
  logic [4:0]  in_load_hours = '0;
  logic [4:0]  in_load_mday = '0;
  logic [3:0]  in_load_month = '0;
  logic [15:0] in_load_year = '0;
  logic [8:0]  in_load_yday = '0;
  logic [2:0]  in_load_wday = '0;
  logic        in_load_dst = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  out_seconds;
  logic [5:0]  out_minutes;
  logic [4:0]  out_hours;
  logic [4:0]  out_mday;
  logic [3:0]  out_month;
  logic [15:0] out_year;
  logic [8:0]  out_yday;
  logic [2:0]  out_wday;
  logic        out_dst;

  calendar_clock_counter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_load_seconds (in_load_seconds),
    .in_load_minutes (in_load_minutes),
    .in_load_hours   (in_load_hours),
    .in_load_mday    (in_load_mday),
    .in_load_month   (in_load_month),
    .in_load_year    (in_load_year),
    .in_load_yday    (in_load_yday),
    .in_load_wday    (in_load_wday),
    .in_load_dst     (in_load_dst),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_seconds     (out_seconds),
    .out_minutes     (out_minutes),
    .out_hours       (out_hours),
    .out_mday        (out_mday),
    .out_month       (out_month),
    .out_year        (out_year),
    .out_yday        (out_yday),
    .out_wday        (out_wday),
    .out_dst         (out_dst)
  );

  int    month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  stim_t pending_items [$];
  cal_t  expected_times [$];
  cal_t  clock_state;
  stim_t cur_item;
  int    burst_left;
  int    gap_left;
  int    items_sent;
  int    total_items;
  int    results_seen;
  int    mismatches;
  int    rx_cycle;
  int    rx_taken;
  int    hold_left;
  bit    hold_done;
  int    quiet_cycles;

  always #4 clk = ~clk;

  function automatic bit leap_year(logic [15:0] y);
    int yi;
    yi = int'(y);
    return (yi % calclk_pkg::LEAP_CYCLE == 0) ||
           ((yi % calclk_pkg::CENTURY != 0) && (yi % 4 == 0));
  endfunction

  function automatic cal_t tick_time(cal_t s);
    cal_t n;
    int   len;
    n = s;
    if (int'(s.seconds) + 1 < calclk_pkg::SEC_PER_MIN) begin
      n.seconds = s.seconds + 6'd1;
      return n;
    end
    n.seconds = '0;
    if (int'(s.minutes) + 1 < calclk_pkg::MIN_PER_HOUR) begin
      n.minutes = s.minutes + 6'd1;
      return n;
    end
    n.minutes = '0;
    if (int'(s.hours) + 1 < calclk_pkg::HOUR_PER_DAY) begin
      n.hours = s.hours + 5'd1;
      return n;
    end
    n.hours = '0;
    n.yday = s.yday + 9'd1;
    if (int'(s.month) > calclk_pkg::LAST_MONTH) begin
      len = 31;
    end else begin
      len = month_days[s.month];
      if (int'(s.month) == FEBRUARY && leap_year(s.year)) begin
        len = len + 1;
      end
    end
    if (int'(s.mday) + 1 <= len) begin
      n.mday = s.mday + 5'd1;
      return n;
    end
    n.mday = 5'd1;
    if (int'(s.month) + 1 <= calclk_pkg::LAST_MONTH) begin
      n.month = s.month + 4'd1;
      return n;
    end
    n.month = '0;
    n.yday = '0;
    n.year = s.year + 16'd1;
    return n;
  endfunction

  function automatic cal_t random_payload();
    cal_t t;
    t.seconds = 6'($urandom);
    t.minutes = 6'($urandom);
    t.hours   = 5'($urandom);
    t.mday    = 5'($urandom);
    t.month   = 4'($urandom);
    t.year    = 16'($urandom);
    t.yday    = 9'($urandom);
    t.wday    = 3'($urandom);
    t.dst     = 1'($urandom);
    return t;
  endfunction

  // loads biased toward the edges of the carry chain
  function automatic cal_t near_rollover();
    cal_t t;
    int   r;
    t = random_payload();
    if ($urandom_range(0, 3) != 0) t.seconds = 6'($urandom_range(56, 63));
    if ($urandom_range(0, 9) < 7) t.minutes = 6'($urandom_range(59, 63));
    if ($urandom_range(0, 9) < 7) t.hours = 5'($urandom_range(23, 31));
    if ($urandom_range(0, 9) < 6) t.mday = 5'($urandom_range(27, 31));
    r = $urandom_range(0, 9);
    if (r < 3) t.month = 4'(FEBRUARY);
    else if (r < 5) t.month = 4'(calclk_pkg::LAST_MONTH);
    r = $urandom_range(0, 9);
    if (r < 2) t.year = 16'(calclk_pkg::LEAP_CYCLE * $urandom_range(0, 163));
    else if (r < 4) t.year = 16'(calclk_pkg::CENTURY * $urandom_range(0, 655));
    else if (r < 6) t.year = 16'(4 * $urandom_range(0, 16383));
    else if (r == 6) t.year = '1;
    return t;
  endfunction

  task automatic add_load(cal_t t);
    stim_t s;
    s.kind = calclk_pkg::REQ_LOAD;
    s.load = t;
    pending_items.push_back(s);
  endtask

  task automatic add_ticks(int n);
    stim_t s;
    for (int i = 0; i < n; i++) begin
      s.kind = calclk_pkg::REQ_TICK;
      s.load = random_payload();
      pending_items.push_back(s);
    end
  endtask

  task automatic check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("mismatch on %s at result %0d: expected %0d, got %0d",
                 name, results_seen, want_v, got_v);
      end
    end
  endtask

  // driver, also predicts the result of each input transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      clock_state = RESET_TIME;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        if (cur_item.kind == calclk_pkg::REQ_LOAD) begin
          clock_state = cur_item.load;
        end else begin
          clock_state = tick_time(clock_state);
        end
        expected_times.push_back(clock_state);
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          in_valid        <= 1'b1;
          in_req_type     <= cur_item.kind;
          in_load_seconds <= cur_item.load.seconds;
          in_load_minutes <= cur_item.load.minutes;
          in_load_hours   <= cur_item.load.hours;
          in_load_mday    <= cur_item.load.mday;
          in_load_month   <= cur_item.load.month;
          in_load_year    <= cur_item.load.year;
          in_load_yday    <= cur_item.load.yday;
          in_load_wday    <= cur_item.load.wday;
          in_load_dst     <= cur_item.load.dst;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: ready density steps through 25/50/75/100 percent,
  // with one long hold-off to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_cycle = 0;
      rx_taken = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      rx_cycle++;
      if (out_valid && out_ready) rx_taken++;
      if (!hold_done && rx_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 3) < int'(rx_cycle[8:7]) + 1);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cal_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_times.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result %0d with nothing pending", results_seen);
        end
      end else begin
        want = expected_times.pop_front();
        check_field("seconds", 16'(want.seconds), 16'(out_seconds));
        check_field("minutes", 16'(want.minutes), 16'(out_minutes));
        check_field("hours", 16'(want.hours), 16'(out_hours));
        check_field("mday", 16'(want.mday), 16'(out_mday));
        check_field("month", 16'(want.month), 16'(out_month));
        check_field("year", want.year, out_year);
        check_field("yday", 16'(want.yday), 16'(out_yday));
        check_field("wday", 16'(want.wday), 16'(out_wday));
        check_field("dst", 16'(want.dst), 16'(out_dst));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int random_count;
    int n;

    // directed: extremes, leap rules, out-of-range counters
    add_ticks(1);
    add_load('{6'd59, 6'd59, 5'd23, 5'd31, 4'd11, 16'hFFFF, 9'd364, 3'd6, 1'b1});
    add_ticks(1);
    add_load('{6'd59, 6'd59, 5'd23, 5'd28, 4'd1, 16'd2000, 9'd58, 3'd1, 1'b0});
    add_ticks(1);
    add_load('{6'd59, 6'd59, 5'd23, 5'd29, 4'd1, 16'd2000, 9'd59, 3'd2, 1'b1});
    add_ticks(1);
    add_load('{6'd59, 6'd59, 5'd23, 5'd28, 4'd1, 16'd1900, 9'd58, 3'd3, 1'b0});
    add_ticks(1);
    add_load('{6'd59, 6'd59, 5'd23, 5'd28, 4'd1, 16'd2024, 9'd58, 3'd4, 1'b0});
    add_ticks(1);
    add_load('{6'd59, 6'd59, 5'd23, 5'd28, 4'd1, 16'd2023, 9'd58, 3'd5, 1'b1});
    add_ticks(1);
    add_load('{6'd63, 6'd63, 5'd31, 5'd31, 4'd3, 16'd7, 9'd100, 3'd0, 1'b0});
    add_ticks(1);
    add_load('{6'd59, 6'd59, 5'd23, 5'd0, 4'd5, 16'd12, 9'd150, 3'd1, 1'b0});
    add_ticks(1);
    add_load('{6'd59, 6'd59, 5'd23, 5'd31, 4'd15, 16'd100, 9'd400, 3'd2, 1'b1});
    add_ticks(1);
    add_load('{6'd59, 6'd59, 5'd23, 5'd30, 4'd12, 16'd1, 9'd370, 3'd3, 1'b0});
    add_ticks(1);
    add_load('{6'd59, 6'd59, 5'd23, 5'd5, 4'd0, 16'd3, 9'd511, 3'd4, 1'b0});
    add_ticks(1);
    add_load('1);
    add_ticks(1);
    add_load('0);
    add_ticks(1);

    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        stim_t s;
        s.kind = calclk_pkg::req_t'($urandom_range(0, 1));
        s.load = random_payload();
        pending_items.push_back(s);
        random_count++;
      end else begin
        add_load(near_rollover());
        n = $urandom_range(1, 10);
        add_ticks(n);
        random_count += n + 1;
      end
    end
    total_items = pending_items.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (items_sent < total_items) @(posedge clk);
    while (expected_times.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_times.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
